/* rtl/core/smm_pkg.sv */
// Shared types and constants for the square matrix multiply core.
// No dependencies; used by smm_mac and square_matrix_multiply_core.
package smm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SIZE_W = 4;
  localparam int unsigned POS_W  = 3;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

/* rtl/core/square_matrix_multiply_core.sv */
// Square signed 32-bit matrix multiplier, top level.
// Depends on smm_pkg and smm_mac.
//
// Load n*n request pairs (A element, B element, row-major), one per cycle. After the
// last pair the core stops taking requests and computes C = A*B, one element at a
// time through a single shared multiply-accumulate unit fed from the two operand
// memories: for each element the operand reads run first, then the accumulate
// pipeline drains and hands the sum to the output register once that register is
// free, waiting while m_tready holds the previous result back. C leaves
// in row-major order, tlast on the final element. Products and sums wrap modulo
// 2^32. A size write resets the partial load and holds off requests in that cycle;
// size 0 acts as 1, sizes above MAX_SIZE act as MAX_SIZE. Operand stores need no
// clearing: every entry is written before it is read.
module square_matrix_multiply_core #(
  parameter int unsigned MAX_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,     // matrix_size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,      // a_element[31:0], b_element[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,      // product_element[31:0], out_row[34:32],
                                    // out_col[37:35], zero[39:38]
  output logic        m_tlast       // last_of_run
);

  localparam int unsigned DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LC_W   = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SIZE + 1);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  n_act;
  logic [LC_W-1:0]   load_count;
  logic [LC_W-1:0]   total;
  logic [IDX_W-1:0]  r, c, k;
  logic              res_pend;
  logic              slot_free;
  logic              out_load;
  logic              k_last;
  logic              elem_last;
  logic [ADDR_W-1:0] a_addr, b_addr;

  smm_pkg::word_t    a_mem [DEPTH];
  smm_pkg::word_t    b_mem [DEPTH];
  smm_pkg::word_t    rd_a, rd_b;
  smm_pkg::mac_ctl_t ctl;
  logic              mac_done;
  smm_pkg::word_t    mac_sum;

  smm_pkg::word_t            out_data;
  logic [smm_pkg::POS_W-1:0] out_row, out_col;

  assign cfg_ready = (state == ST_LOAD);
  assign s_tready  = (state == ST_LOAD) && !cfg_valid;
  assign slot_free = !m_tvalid || m_tready;
  assign out_load  = (state == ST_FLUSH) && res_pend && slot_free;
  assign total     = LC_W'(n_act) * LC_W'(n_act);
  assign k_last    = (CNT_W'(k) == n_act - CNT_W'(1));
  assign elem_last = (CNT_W'(r) == n_act - CNT_W'(1)) && (CNT_W'(c) == n_act - CNT_W'(1));
  assign a_addr    = ADDR_W'(r) * ADDR_W'(n_act) + ADDR_W'(k);
  assign b_addr    = ADDR_W'(k) * ADDR_W'(n_act) + ADDR_W'(c);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_mem[load_count[ADDR_W-1:0]] <= s_tdata[31:0];
      b_mem[load_count[ADDR_W-1:0]] <= s_tdata[63:32];
    end
    rd_a <= a_mem[a_addr];
    rd_b <= b_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= (state == ST_ISSUE);
      ctl.first <= (k == '0);
      ctl.last  <= k_last;
    end
  end

  smm_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .x    (rd_a),
    .y    (rd_b),
    .done (mac_done),
    .sum  (mac_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      n_act      <= CNT_W'(MAX_SIZE);
      load_count <= '0;
      r          <= '0;
      c          <= '0;
      k          <= '0;
      res_pend   <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tlast    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (mac_done) begin
        res_pend <= 1'b1;
      end
      unique case (state)
        ST_LOAD: begin
          if (cfg_valid) begin
            load_count <= '0;
            if (cfg_data == '0) begin
              n_act <= CNT_W'(1);
            end else if (cfg_data > smm_pkg::SIZE_W'(MAX_SIZE)) begin
              n_act <= CNT_W'(MAX_SIZE);
            end else begin
              n_act <= CNT_W'(cfg_data);
            end
          end else if (s_tvalid) begin
            if (load_count == total - LC_W'(1)) begin
              load_count <= '0;
              r          <= '0;
              c          <= '0;
              k          <= '0;
              state      <= ST_ISSUE;
            end else begin
              load_count <= load_count + LC_W'(1);
            end
          end
        end
        ST_ISSUE: begin
          if (k_last) begin
            k     <= '0;
            state <= ST_FLUSH;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        ST_FLUSH: begin
          if (out_load) begin
            res_pend <= 1'b0;
            m_tlast  <= elem_last;
            if (elem_last) begin
              state <= ST_LOAD;
            end else begin
              state <= ST_ISSUE;
              if (CNT_W'(c) == n_act - CNT_W'(1)) begin
                c <= '0;
                r <= r + IDX_W'(1);
              end else begin
                c <= c + IDX_W'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= mac_sum;
      out_row  <= smm_pkg::POS_W'(r);
      out_col  <= smm_pkg::POS_W'(c);
    end
  end

  assign m_tdata = {2'b00, out_col, out_row, out_data};

  a_done_in_flush: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == ST_FLUSH))
    else $error("accumulate finished outside flush");

  a_pend_in_flush: assert property (@(posedge clk) disable iff (rst)
    res_pend |-> (state == ST_FLUSH))
    else $error("pending result outside flush");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |-> (CNT_W'(k) < n_act))
    else $error("inner index beyond matrix size");

  a_load_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (load_count < total))
    else $error("load count beyond matrix area");

endmodule

/* rtl/core/smm_mac.sv */
// Shared multiply-accumulate unit: one registered multiply, then one accumulate.
// Depends on smm_pkg for the word and control types.
module smm_mac (
  input  logic             clk,
  input  logic             rst,
  input  smm_pkg::mac_ctl_t ctl,
  input  smm_pkg::word_t   x,
  input  smm_pkg::word_t   y,
  output logic             done,
  output smm_pkg::word_t   sum
);

  smm_pkg::word_t               full;
  smm_pkg::word_t               prod;
  smm_pkg::mac_ctl_t            ctl_q;

  assign full = x * y;

  always_ff @(posedge clk) begin
    prod <= full;
    if (rst) begin
      ctl_q <= '0;
      done  <= 1'b0;
    end else begin
      ctl_q <= ctl;
      done  <= ctl_q.valid & ctl_q.last;
    end
    if (ctl_q.valid) begin
      sum <= (ctl_q.first ? '0 : sum) + prod;
    end
  end

endmodule
